[src/mmips_pkg.sv]
// ----------------------------------------------------------------------------
// mmips_pkg
// Shared types and opcode constants for the miniature 16-register processor.
// ----------------------------------------------------------------------------
package mmips_pkg;

  localparam logic [3:0] OP_ADD  = 4'd0;
  localparam logic [3:0] OP_SUB  = 4'd1;
  localparam logic [3:0] OP_SLT  = 4'd2;
  localparam logic [3:0] OP_OR   = 4'd3;
  localparam logic [3:0] OP_NAND = 4'd4;
  localparam logic [3:0] OP_ADDI = 4'd5;
  localparam logic [3:0] OP_SLTI = 4'd6;
  localparam logic [3:0] OP_ORI  = 4'd7;
  localparam logic [3:0] OP_LUI  = 4'd8;
  localparam logic [3:0] OP_LW   = 4'd9;
  localparam logic [3:0] OP_SW   = 4'd10;
  localparam logic [3:0] OP_BEQ  = 4'd11;
  localparam logic [3:0] OP_JALR = 4'd12;
  localparam logic [3:0] OP_J    = 4'd13;
  localparam logic [3:0] OP_HALT = 4'd14;

  localparam logic OPER_LOAD = 1'b0;
  localparam logic OPER_STEP = 1'b1;

  typedef struct packed {
    logic [9:0]  program_counter;
    logic        halted;
    logic        reg_write;
    logic [3:0]  dest_reg;
    logic [31:0] write_value;
    logic [31:0] mem_accesses;
    logic [3:0]  regs_in_use;
    logic [31:0] instr_count;
    logic        address_fault;
  } result_t;

  typedef struct packed {
    logic        operation;
    logic [9:0]  load_address;
    logic [31:0] load_data;
  } request_t;

endpackage

[src/mmips_if.sv]
// ----------------------------------------------------------------------------
// mmips_if
// Valid/ready channel carrying one payload of a given type.
// ----------------------------------------------------------------------------
interface mmips_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[src/mini_mips_instruction_step.sv]
// ----------------------------------------------------------------------------
// mini_mips_instruction_step
// A load result is registered through ST_DONE; a step result passes through
// ST_FETCH, ST_EXEC, ST_DATA and ST_DONE (fetch, register read and address, data
// access, writeback). The result is held until taken and input stalls meanwhile.
// ----------------------------------------------------------------------------
// Reset clears pc, halt, counters and register-used flags; the register file
// clears through those flags; word memory is undefined until written.
module mini_mips_instruction_step
  import mmips_pkg::*;
#(
  parameter int MEM_DEPTH = 1024
) (
  input  logic clk,
  input  logic rst_n,
  mmips_if.sink   in_ch,
  mmips_if.source out_ch
);
  localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FETCH = 3'd1;
  localparam logic [2:0] ST_EXEC  = 3'd2;
  localparam logic [2:0] ST_DATA  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]  state_r, state_nxt;
  logic [9:0]  pc_r;
  logic        halt_r;
  logic [31:0] acc_r, exe_r;
  logic [15:0] used_r;
  logic [31:0] regs_r [16];
  logic        out_valid_r;
  result_t     res_r;
  logic [31:0] ins_r, a_r, b_r;
  logic [31:0] ea_r;

  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [31:0]   mem_wdata, mem_rdata;

  mmips_mem #(.DEPTH(MEM_DEPTH), .AW(AW)) u_mem (
    .clk(clk), .we(mem_we), .addr(mem_addr), .wdata(mem_wdata), .rdata(mem_rdata)
  );

  wire in_fire = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == ST_IDLE) && !out_valid_r;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = res_r;

  wire [31:0] ins = mem_rdata;
  wire [3:0]  op  = ins_r[27:24];
  wire [3:0]  rt  = ins_r[19:16];
  wire [3:0]  rd  = ins_r[15:12];
  wire [31:0] zimm = {16'd0, ins_r[15:0]};
  wire [31:0] simm = {{16{ins_r[15]}}, ins_r[15:0]};
  wire [9:0]  pc1  = pc_r + 10'd1;
  wire        pc_in = ({22'd0, pc_r} < 32'(MEM_DEPTH));
  wire        ea_ok = (ea_r < 32'(MEM_DEPTH));

  function automatic logic [3:0] count_used(logic [15:0] f);
    logic [3:0] c;
    c = '0;
    for (int k = 1; k < 16; k++) c = c + 4'(f[k]);
    return c;
  endfunction

  function automatic logic [31:0] sat(logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = '0;
    mem_wdata = b_r;
    if (state_r == ST_IDLE) begin
      mem_addr  = AW'(pc_r);
      mem_wdata = in_ch.data.load_data;
      if (in_fire && in_ch.data.operation == OPER_LOAD) begin
        mem_addr = AW'(in_ch.data.load_address);
        mem_we   = ({22'd0, in_ch.data.load_address} < 32'(MEM_DEPTH));
      end
    end else if (state_r == ST_EXEC) begin
      mem_addr = AW'(ea_r);
      mem_we   = (op == OP_SW) && ea_ok;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_fire) begin
        state_nxt = (in_ch.data.operation == OPER_STEP && !halt_r) ? ST_FETCH : ST_DONE;
      end
      ST_FETCH: state_nxt = ST_EXEC;
      ST_EXEC:  state_nxt = ST_DATA;
      ST_DATA:  state_nxt = ST_DONE;
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pc_r        <= '0;
      halt_r      <= 1'b0;
      acc_r       <= '0;
      exe_r       <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_ch.valid && out_ch.ready) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: if (in_fire) begin
          res_r.reg_write     <= 1'b0;
          res_r.dest_reg      <= '0;
          res_r.write_value   <= '0;
          res_r.address_fault <= (in_ch.data.operation == OPER_LOAD) &&
                                 ({22'd0, in_ch.data.load_address} >= 32'(MEM_DEPTH));
        end
        ST_FETCH: begin
          // register read; unused registers read as zero
          ins_r <= pc_in ? ins : 32'd0;
          a_r   <= (pc_in && used_r[ins[23:20]]) ? regs_r[ins[23:20]] : 32'd0;
          b_r   <= (pc_in && used_r[ins[19:16]]) ? regs_r[ins[19:16]] : 32'd0;
          ea_r  <= ((pc_in && used_r[ins[23:20]]) ? regs_r[ins[23:20]] : 32'd0)
                   + {{16{ins[15]}}, ins[15:0]};
        end
        ST_EXEC: ;
        ST_DATA: begin
          logic        w;
          logic [3:0]  dst;
          logic [31:0] r;
          logic [9:0]  nx;
          w = 1'b0; dst = rt; r = '0; nx = pc1;
          case (op)
            OP_ADD:  begin r = a_r + b_r; dst = rd; w = 1'b1; end
            OP_SUB:  begin r = a_r - b_r; dst = rd; w = 1'b1; end
            OP_SLT:  begin r = {31'd0, $signed(a_r) < $signed(b_r)}; dst = rd; w = 1'b1; end
            OP_OR:   begin r = a_r | b_r; dst = rd; w = 1'b1; end
            OP_NAND: begin r = ~(a_r & b_r); dst = rd; w = 1'b1; end
            OP_ADDI: begin r = a_r + simm; w = 1'b1; end
            OP_SLTI: begin r = {31'd0, $signed(a_r) < $signed(simm)}; w = 1'b1; end
            OP_ORI:  begin r = a_r | zimm; w = 1'b1; end
            OP_LUI:  begin r = {ins_r[15:0], 16'd0}; w = 1'b1; end
            OP_LW:   begin r = mem_rdata; w = ea_ok; end
            OP_BEQ:  if (a_r == b_r) nx = pc1 + simm[9:0];
            OP_JALR: begin
              r = {22'd0, pc1}; w = 1'b1;
              // rt is written first, so rs equal to a nonzero rt jumps to pc+1
              nx = (ins_r[23:20] == rt && rt != 4'd0) ? pc1 : a_r[9:0];
            end
            OP_J:    nx = simm[9:0];
            OP_HALT: begin nx = pc_r; halt_r <= 1'b1; end
            default: ;
          endcase
          if (op == OP_LW || op == OP_SW) acc_r <= sat(acc_r);
          exe_r <= sat(exe_r);
          pc_r  <= nx;
          w = w && (dst != 4'd0);
          if (w) begin
            regs_r[dst] <= r;
            used_r[dst] <= 1'b1;
          end
          res_r.reg_write     <= w;
          res_r.dest_reg      <= w ? dst : 4'd0;
          res_r.write_value   <= w ? r : 32'd0;
          res_r.address_fault <= (op == OP_LW || op == OP_SW) && !ea_ok;
        end
        ST_DONE: begin
          res_r.program_counter <= pc_r;
          res_r.halted          <= halt_r;
          res_r.mem_accesses    <= acc_r;
          res_r.instr_count     <= exe_r;
          res_r.regs_in_use     <= count_used(used_r);
          out_valid_r           <= 1'b1;
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTH
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ch.ready) else $error("accept while busy");
  a_halt_holds: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> halt_r) else $error("halt cleared");
  a_reg0_unused: assert property (@(posedge clk) disable iff (!rst_n)
    !used_r[0]) else $error("register zero marked used");
`endif
endmodule

[src/mmips_mem.sv]
// ----------------------------------------------------------------------------
// mmips_mem
// Single-port word memory with registered read.
// ----------------------------------------------------------------------------
module mmips_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [31:0]   wdata,
  output logic [31:0]   rdata
);
  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Checks the miniature processor: loads small random programs into word
// memory, steps them under random handshake gaps, and compares every result
// with an in-bench instruction-set predictor.
// ----------------------------------------------------------------------------
module tb_top
  import mmips_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 1024;
  localparam int STALL_LIMIT = 20000;
  localparam logic [3:0] OP_NOP = 4'd15;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  mmips_if #(.payload_t(request_t)) in_ch ();
  mmips_if #(.payload_t(result_t)) out_ch ();

  mini_mips_instruction_step #(.MEM_DEPTH(DEPTH)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  // predictor state
  logic [31:0] cpu_regs [16];
  bit          cpu_used [16];
  logic [31:0] cpu_mem [DEPTH];
  bit          mem_written [DEPTH];
  logic [9:0]  cpu_pc;
  bit          cpu_halted;
  logic [31:0] cpu_accesses;
  logic [31:0] cpu_executed;

  request_t pending_requests[$];
  result_t  expected_results[$];
  int       mismatches = 0;
  int       idle_cycles = 0;
  bit       hold_sink = 1'b0;
  bit       stim_done = 1'b0;
  int       src_gap = 0;
  int       sink_gap = 0;

  function automatic logic [31:0] sat_inc(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic logic [31:0] get_reg(logic [3:0] i);
    return (i == 4'd0) ? 32'd0 : cpu_regs[i];
  endfunction

  function automatic result_t execute_request(request_t r);
    result_t     res;
    logic [31:0] ins, a, b, zimm, simm, val, ea;
    logic [3:0]  op, rs, rt, rd, dst;
    logic [9:0]  nxt;
    bit          w;
    int          n;
    res = '0;
    w = 0;
    dst = 0;
    val = 0;
    if (r.operation == OPER_LOAD) begin
      cpu_mem[r.load_address] = r.load_data;
      mem_written[r.load_address] = 1'b1;
    end else if (!cpu_halted) begin
      ins = cpu_mem[cpu_pc];
      op = ins[27:24]; rs = ins[23:20]; rt = ins[19:16]; rd = ins[15:12];
      zimm = {16'd0, ins[15:0]};
      simm = {{16{ins[15]}}, ins[15:0]};
      a = get_reg(rs);
      b = get_reg(rt);
      nxt = cpu_pc + 10'd1;
      case (op)
        OP_ADD:  begin val = a + b; dst = rd; w = 1; end
        OP_SUB:  begin val = a - b; dst = rd; w = 1; end
        OP_SLT:  begin val = ($signed(a) < $signed(b)) ? 1 : 0; dst = rd; w = 1; end
        OP_OR:   begin val = a | b; dst = rd; w = 1; end
        OP_NAND: begin val = ~(a & b); dst = rd; w = 1; end
        OP_ADDI: begin val = a + simm; dst = rt; w = 1; end
        OP_SLTI: begin val = ($signed(a) < $signed(simm)) ? 1 : 0; dst = rt; w = 1; end
        OP_ORI:  begin val = a | zimm; dst = rt; w = 1; end
        OP_LUI:  begin val = zimm << 16; dst = rt; w = 1; end
        OP_LW, OP_SW: begin
          ea = a + simm;
          cpu_accesses = sat_inc(cpu_accesses);
          if (ea >= DEPTH) begin
            res.address_fault = 1'b1;
          end else if (op == OP_LW) begin
            val = cpu_mem[ea]; dst = rt; w = 1;
          end else begin
            cpu_mem[ea] = b;
            mem_written[ea] = 1'b1;
          end
        end
        OP_BEQ: if (a == b) nxt = cpu_pc + 10'd1 + simm[9:0];
        OP_JALR: begin
          val = {22'd0, nxt}; dst = rt; w = 1;
          if (rt != 0) cpu_regs[rt] = val;
          ea = get_reg(rs);
          nxt = ea[9:0];
          w = (rt != 0);
          if (w) cpu_used[rt] = 1'b1;
        end
        OP_J:    nxt = simm[9:0];
        OP_HALT: begin cpu_halted = 1'b1; nxt = cpu_pc; end
        default: ;
      endcase
      if (w && dst != 0) begin
        cpu_regs[dst] = val;
        cpu_used[dst] = 1'b1;
        res.reg_write = 1'b1;
        res.dest_reg = dst;
        res.write_value = val;
      end
      cpu_pc = nxt;
      cpu_executed = sat_inc(cpu_executed);
    end
    n = 0;
    for (int k = 1; k < 16; k++) n += cpu_used[k];
    res.program_counter = cpu_pc;
    res.halted = cpu_halted;
    res.mem_accesses = cpu_accesses;
    res.regs_in_use = n[3:0];
    res.instr_count = cpu_executed;
    return res;
  endfunction

  function automatic request_t load_req(int unsigned adr, logic [31:0] d);
    request_t r;
    r.operation = OPER_LOAD;
    r.load_address = adr[9:0];
    r.load_data = d;
    return r;
  endfunction

  function automatic request_t step_req();
    request_t r;
    r.operation = OPER_STEP;
    r.load_address = 10'($urandom);
    r.load_data = $urandom;
    return r;
  endfunction

  function automatic logic [31:0] encode(logic [3:0] op, logic [3:0] rs, logic [3:0] rt,
                                         logic [15:0] imm);
    return {$urandom_range(15, 0) % 16 == 0 ? 4'hF : 4'h0, op, rs, rt, imm};
  endfunction

  // Random instruction; keeps fetches in written memory and points data accesses
  // through register zero at a preloaded window or, at times, out of range.
  function automatic logic [31:0] random_instr(int unsigned base, int unsigned len);
    logic [3:0]  op, rs, rt;
    logic [15:0] imm;
    op = 4'($urandom_range(15, 0));
    rs = 4'($urandom);
    rt = 4'($urandom);
    imm = 16'($urandom);
    case (op)
      OP_LW: begin
        rs = 0;
        case ($urandom_range(3, 0))
          0: imm = 16'(16'hFFFF - $urandom_range(5, 0));
          1: imm = 16'(DEPTH + $urandom_range(100, 0));
          default: imm = 16'(900 + $urandom_range(31, 0));
        endcase
      end
      OP_SW: begin
        rs = 0;
        imm = ($urandom_range(3, 0) == 0) ? 16'(16'h8000 + $urandom_range(9, 0))
                                          : 16'(900 + $urandom_range(31, 0));
      end
      OP_BEQ: imm = 16'($urandom_range(3, 0)) - 16'd1;
      OP_J:   imm = 16'(base + $urandom_range(len - 1, 0));
      OP_JALR: begin
        rs = 0;
        op = (base == 0) ? OP_JALR : OP_J;
        imm = 16'(base + $urandom_range(len - 1, 0));
      end
      // halt would freeze the rest of the run
      OP_HALT: op = OP_NOP;
      default: ;
    endcase
    return encode(op, rs, rt, imm);
  endfunction

  // Fill the whole memory once so every fetch and in-range load hits written words.
  task automatic clear_memory();
    for (int i = 0; i < DEPTH; i++) pending_requests.push_back(load_req(i, 32'd0));
  endtask

  task automatic add_program(int unsigned steps);
    int unsigned len;
    len = $urandom_range(24, 4);
    for (int i = 0; i < len; i++) pending_requests.push_back(load_req(i, random_instr(0, len)));
    for (int i = len; i < 40; i++)
      pending_requests.push_back(load_req(i, {4'h0, OP_J, 24'd0}));
    for (int i = 0; i < 32; i++)
      pending_requests.push_back(load_req(900 + i, (i % 2) ? 32'h8000_0000 : $urandom));
    for (int i = 0; i < steps; i++) pending_requests.push_back(step_req());
  endtask

  // Programs keep pc below 40; jump every one of those words to zero and step once.
  task automatic rewind_pc();
    for (int i = 0; i < 40; i++) pending_requests.push_back(load_req(i, {4'h0, OP_J, 24'd0}));
    pending_requests.push_back(step_req());
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid && in_ch.ready)
        expected_results.push_back(execute_request(in_ch.data));
      if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (pending_requests.size() > 0 && pending_requests[0].load_address === 10'bx)
      begin
        // marker: wait for drain
        if (expected_results.size() == 0 && !(in_ch.valid && in_ch.ready)) begin
          void'(pending_requests.pop_front());
        end
        in_ch.valid <= 1'b0;
      end else if (pending_requests.size() > 0) begin
        in_ch.data <= pending_requests.pop_front();
        in_ch.valid <= 1'b1;
        src_gap <= ($urandom_range(9, 0) == 0) ? $urandom_range(20, 1)
                 : ($urandom_range(2, 0) == 0) ? $urandom_range(2, 1) : 0;
      end else begin
        in_ch.valid <= 1'b0;
        if (!in_ch.valid || in_ch.ready) stim_done <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    result_t exp_r;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_ch.data);
        end else begin
          exp_r = expected_results.pop_front();
          if (out_ch.data !== exp_r) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", exp_r, out_ch.data);
          end
        end
      end
      if (hold_sink) begin
        out_ch.ready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap <= sink_gap - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        sink_gap <= ($urandom_range(9, 0) == 0) ? $urandom_range(25, 1)
                  : ($urandom_range(2, 0) == 0) ? $urandom_range(2, 1) : 0;
      end
    end
  end

  // long receiver hold-off
  initial begin
    repeat (3000) @(posedge clk);
    hold_sink = 1'b1;
    repeat (400) @(posedge clk);
    hold_sink = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    request_t drain;
    for (int i = 0; i < 16; i++) begin cpu_regs[i] = 0; cpu_used[i] = 0; end
    for (int i = 0; i < DEPTH; i++) begin cpu_mem[i] = 0; mem_written[i] = 0; end
    cpu_pc = 0; cpu_halted = 0; cpu_accesses = 0; cpu_executed = 0;
    drain = '0;
    drain.load_address = 'x;
    clear_memory();
    // random programs first; halt never appears in them
    for (int p = 0; p < 4; p++) begin
      add_program(60);
      pending_requests.push_back(drain);
    end
    rewind_pc();
    // directed: each opcode at extremes, ending on halt and steps after it
    pending_requests.push_back(load_req(1023, 32'hFFFF_FFFF));
    pending_requests.push_back(load_req(900, 32'h8000_0000));
    pending_requests.push_back(load_req(0, {4'h0, OP_LUI, 4'd0, 4'd1, 16'hFFFF}));
    pending_requests.push_back(load_req(1, {4'h0, OP_ORI, 4'd1, 4'd1, 16'h8001}));
    pending_requests.push_back(load_req(2, {4'h0, OP_ADDI, 4'd0, 4'd2, 16'h8000}));
    pending_requests.push_back(load_req(3, {4'h0, OP_ADD, 4'd1, 4'd2, 4'd3, 12'd0}));
    pending_requests.push_back(load_req(4, {4'h0, OP_SUB, 4'd1, 4'd2, 4'd0, 12'd0}));
    pending_requests.push_back(load_req(5, {4'h0, OP_SLT, 4'd1, 4'd2, 4'd4, 12'd0}));
    pending_requests.push_back(load_req(6, {4'h0, OP_OR, 4'd1, 4'd2, 4'd15, 12'd0}));
    pending_requests.push_back(load_req(7, {4'h0, OP_NAND, 4'd1, 4'd2, 4'd5, 12'd0}));
    pending_requests.push_back(load_req(8, {4'h0, OP_SLTI, 4'd2, 4'd6, 16'h7FFF}));
    pending_requests.push_back(load_req(9, {4'h0, OP_LW, 4'd0, 4'd7, 16'd900}));
    pending_requests.push_back(load_req(10, {4'h0, OP_SW, 4'd1, 4'd1, 16'd0}));
    pending_requests.push_back(load_req(11, {4'h0, OP_LW, 4'd0, 4'd7, 16'hFFFF}));
    pending_requests.push_back(load_req(12, {4'hF, OP_NOP, 24'hFFFFFF}));
    pending_requests.push_back(load_req(13, {4'h0, OP_BEQ, 4'd0, 4'd0, 16'd1}));
    pending_requests.push_back(load_req(15, {4'h0, OP_JALR, 4'd8, 4'd8, 16'd0}));
    pending_requests.push_back(load_req(16, {4'h0, OP_J, 24'd1023}));
    pending_requests.push_back(load_req(1023, {4'h0, OP_J, 24'd20}));
    pending_requests.push_back(load_req(20, {4'h0, OP_HALT, 24'hFFFFFF}));
    for (int i = 0; i < 20; i++) pending_requests.push_back(step_req());
    pending_requests.push_back(drain);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    wait (stim_done && expected_results.size() == 0);
    repeat (50) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
